// File: design/assert_macros.svh
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Checks that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// File: design/rrps_pkg.sv
// Types and constants shared by the round-robin packet scheduler.
`timescale 1ns / 1ps
package rrps_pkg;
   localparam int TIME_WIDTH = 32;
   localparam int RATE_WIDTH = 24;
   localparam int LEN_WIDTH = 16;
   localparam int ID_WIDTH = 16;
   localparam int QNUM_WIDTH = 4;
   localparam int QUOT_WIDTH = LEN_WIDTH + 16;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic start;
      logic done;
      logic overflow;
   } div_ctrl_type;
endpackage

// File: design/round_robin_packet_scheduler_top.sv
// Top level of the round-robin packet scheduler.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Packets load at one per cycle while busy is low. The packet with last set
// starts service: busy stays high while the schedule is worked out, and each
// finished packet appears on the rsp_ ports for one cycle under rsp_valid;
// the receiver cannot stall them. Each result waits on the one-bit-per-cycle
// divider for the service time, on a step per queue visited, and on a scan
// of the queues when no queue holds a packet that has arrived.
module round_robin_packet_scheduler_top import rrps_pkg::*; #(
   parameter int PACKET_CAPACITY = 64,
   parameter int QUEUE_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [TIME_WIDTH-1:0] req_arrival_time,
   input  logic [ID_WIDTH-1:0]   req_packet_id,
   input  logic [QNUM_WIDTH-1:0] req_queue_number,
   input  logic [LEN_WIDTH-1:0]  req_packet_length,
   input  logic                  req_last_packet,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RATE_WIDTH-1:0] csr_service_rate,
   output logic                  rsp_valid,
   output logic [TIME_WIDTH-1:0] rsp_finish_time,
   output logic [ID_WIDTH-1:0]   rsp_served_id,
   output logic [QNUM_WIDTH-1:0] rsp_served_queue,
   output logic                  rsp_final_result
);
   localparam int SW = $clog2(PACKET_CAPACITY);
   localparam int CNTW = $clog2(PACKET_CAPACITY + 1);
   localparam int QW = $clog2(QUEUE_COUNT);

   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [TIME_WIDTH-1:0] arrival_mem [PACKET_CAPACITY];
   logic [ID_WIDTH-1:0]   id_mem [PACKET_CAPACITY];
   logic [LEN_WIDTH-1:0]  length_mem [PACKET_CAPACITY];
   logic [SW-1:0]         link_mem [PACKET_CAPACITY];

   logic [SW-1:0]         head_ff [QUEUE_COUNT];
   logic [SW-1:0]         tail_ff [QUEUE_COUNT];
   logic [QUEUE_COUNT-1:0] occ_ff;
   logic [TIME_WIDTH-1:0] head_arr_ff [QUEUE_COUNT];
   logic [CNTW-1:0]       left_ff;
   logic [QNUM_WIDTH-1:0] highest_ff;
   logic [TIME_WIDTH-1:0] earliest_ff;
   logic [QNUM_WIDTH-1:0] start_q_ff;
   logic [TIME_WIDTH-1:0] time_ff;
   logic [QNUM_WIDTH-1:0] cur_q_ff;
   logic [RATE_WIDTH-1:0] rate_ff;
   logic [QNUM_WIDTH-1:0] scan_q_ff;
   logic [TIME_WIDTH-1:0] best_ff;
   logic                  found_ff;
   logic [QNUM_WIDTH-1:0] best_q_ff;
   logic [SW-1:0]         slot_ff;
   logic [LEN_WIDTH-1:0]  len_rd_ff;
   logic [ID_WIDTH-1:0]   id_rd_ff;
   logic [SW-1:0]         link_rd_ff;
   logic [TIME_WIDTH-1:0] link_arr_ff;
   logic                  rsp_valid_ff;
   logic [TIME_WIDTH-1:0] rsp_time_ff;
   logic [ID_WIDTH-1:0]   rsp_id_ff;
   logic [QNUM_WIDTH-1:0] rsp_q_ff;
   logic                  rsp_final_ff;

   div_ctrl_type          div_ctrl;
   logic [TIME_WIDTH-1:0] div_quot;
   logic                  div_go;

   logic                  accept;
   logic                  q_ok;
   logic [QW-1:0]         qi;
   logic [QW-1:0]         cqi;
   logic [QW-1:0]         sqi;
   logic [SW-1:0]         rd_slot;
   logic                  cur_ready;
   logic [QUEUE_COUNT-1:0] ready_vec;
   logic [QNUM_WIDTH-1:0] next_q;
   logic [TIME_WIDTH:0]   fin_sum;
   logic [TIME_WIDTH-1:0] fin;

   assign busy = (state_ff != ST_LOAD);
   assign csr_ready = (state_ff == ST_LOAD);
   assign accept = start && !busy;
   assign q_ok = (req_queue_number >= QNUM_WIDTH'(1))
              && ({1'b0, req_queue_number} <= (QNUM_WIDTH+1)'(QUEUE_COUNT));
   assign qi = QW'(req_queue_number - QNUM_WIDTH'(1));
   assign cqi = QW'(cur_q_ff - QNUM_WIDTH'(1));
   assign sqi = QW'(scan_q_ff - QNUM_WIDTH'(1));
   assign rd_slot = head_ff[cqi];
   assign next_q = (cur_q_ff >= highest_ff) ? QNUM_WIDTH'(1) : cur_q_ff + QNUM_WIDTH'(1);

   always_comb begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
         ready_vec[q] = occ_ff[q] && (head_arr_ff[q] <= time_ff)
                     && (QNUM_WIDTH'(q + 1) <= highest_ff);
      end
   end
   assign cur_ready = (cur_q_ff >= QNUM_WIDTH'(1)) && (cur_q_ff <= highest_ff)
                   && ready_vec[cqi];
   assign fin_sum = {1'b0, time_ff} + {1'b0, div_quot};
   assign fin = fin_sum[TIME_WIDTH] ? TIME_MAX : fin_sum[TIME_WIDTH-1:0];
   assign div_go = (state_ff == ST_FETCH);

   rrps_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .length   (len_rd_ff),
      .rate     (rate_ff),
      .ctrl     (div_ctrl),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (accept && q_ok && (left_ff < CNTW'(PACKET_CAPACITY))) begin
         arrival_mem[SW'(left_ff)] <= req_arrival_time;
         id_mem[SW'(left_ff)] <= req_packet_id;
         length_mem[SW'(left_ff)] <= req_packet_length;
         if (occ_ff[qi]) begin
            link_mem[tail_ff[qi]] <= SW'(left_ff);
         end
      end
      len_rd_ff <= length_mem[rd_slot];
      id_rd_ff <= id_mem[rd_slot];
      link_rd_ff <= link_mem[rd_slot];
      link_arr_ff <= arrival_mem[link_rd_ff];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_last_packet) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (left_ff == '0) begin
               state_in = ST_LOAD;
            end else if (ready_vec == '0) begin
               state_in = ST_SCAN;
            end else if (cur_ready) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_DIV;
         ST_DIV: begin
            if (div_ctrl.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: state_in = ST_CHECK;
         ST_SCAN: begin
            if (scan_q_ff >= highest_ff) begin
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         occ_ff <= '0;
         left_ff <= '0;
         highest_ff <= '0;
         earliest_ff <= TIME_MAX;
         start_q_ff <= '0;
         time_ff <= '0;
         cur_q_ff <= '0;
         rate_ff <= RATE_WIDTH'(256);
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            head_ff[q] <= '0;
            tail_ff[q] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            rate_ff <= csr_service_rate;
         end
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (q_ok && (left_ff < CNTW'(PACKET_CAPACITY))) begin
                     if (!occ_ff[qi]) begin
                        head_ff[qi] <= SW'(left_ff);
                        head_arr_ff[qi] <= req_arrival_time;
                     end
                     tail_ff[qi] <= SW'(left_ff);
                     occ_ff[qi] <= 1'b1;
                     if ((left_ff == '0) || (req_arrival_time < earliest_ff)) begin
                        earliest_ff <= req_arrival_time;
                        start_q_ff <= req_queue_number;
                     end
                     if (req_queue_number > highest_ff) begin
                        highest_ff <= req_queue_number;
                     end
                     left_ff <= left_ff + 1'b1;
                  end
                  if (req_last_packet) begin
                     time_ff <= ((left_ff == '0) && !q_ok) ? earliest_ff
                        : (((left_ff == '0) || (req_arrival_time < earliest_ff))
                           && q_ok && (left_ff < CNTW'(PACKET_CAPACITY)))
                           ? req_arrival_time : earliest_ff;
                     cur_q_ff <= (((left_ff == '0) || (req_arrival_time < earliest_ff))
                           && q_ok && (left_ff < CNTW'(PACKET_CAPACITY)))
                           ? req_queue_number : start_q_ff;
                  end
               end
            end
            ST_CHECK: begin
               if (left_ff == '0) begin
                  occ_ff <= '0;
                  highest_ff <= '0;
                  earliest_ff <= TIME_MAX;
                  start_q_ff <= '0;
                  for (int q = 0; q < QUEUE_COUNT; q++) begin
                     head_ff[q] <= '0;
                     tail_ff[q] <= '0;
                  end
               end else if (ready_vec == '0) begin
                  scan_q_ff <= QNUM_WIDTH'(1);
                  found_ff <= 1'b0;
               end else if (cur_ready) begin
                  slot_ff <= head_ff[cqi];
               end else begin
                  cur_q_ff <= next_q;
               end
            end
            ST_SCAN: begin
               if (occ_ff[sqi] && (!found_ff || head_arr_ff[sqi] < best_ff)) begin
                  best_ff <= head_arr_ff[sqi];
                  best_q_ff <= scan_q_ff;
                  found_ff <= 1'b1;
               end
               scan_q_ff <= scan_q_ff + 1'b1;
               if (scan_q_ff >= highest_ff) begin
                  if (occ_ff[sqi] && (!found_ff || head_arr_ff[sqi] < best_ff)) begin
                     time_ff <= head_arr_ff[sqi];
                     cur_q_ff <= scan_q_ff;
                  end else begin
                     time_ff <= best_ff;
                     cur_q_ff <= best_q_ff;
                  end
               end
            end
            ST_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_time_ff <= fin;
               rsp_id_ff <= id_rd_ff;
               rsp_q_ff <= cur_q_ff;
               rsp_final_ff <= (left_ff == CNTW'(1));
               if (tail_ff[cqi] == slot_ff) begin
                  occ_ff[cqi] <= 1'b0;
               end else begin
                  head_ff[cqi] <= link_rd_ff;
                  head_arr_ff[cqi] <= link_arr_ff;
               end
               left_ff <= left_ff - 1'b1;
               time_ff <= fin;
               cur_q_ff <= next_q;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_finish_time = rsp_time_ff;
   assign rsp_served_id = rsp_id_ff;
   assign rsp_served_queue = rsp_q_ff;
   assign rsp_final_result = rsp_final_ff;

   `ASSERT_IMPLY(a_no_csr_when_busy, clock, reset, busy, !csr_ready)
   `ASSERT_NEXT(a_emit_leads_rsp, clock, reset, state_ff == ST_EMIT, rsp_valid)
   `ASSERT_IMPLY(a_rsp_only_busy, clock, reset, rsp_valid, busy)
endmodule

// File: design/rrps_divider.sv
// Restoring divider that computes length * 65536 / service rate, one bit per cycle.
`timescale 1ns / 1ps
module rrps_divider import rrps_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [LEN_WIDTH-1:0]    length,
   input  logic [RATE_WIDTH-1:0]   rate,
   output div_ctrl_type            ctrl,
   output logic [TIME_WIDTH-1:0]   quotient
);
   localparam int CW = $clog2(QUOT_WIDTH + 1);
   logic [QUOT_WIDTH-1:0] dividend_ff, dividend_in;
   logic [QUOT_WIDTH-1:0] quot_ff, quot_in;
   logic [RATE_WIDTH:0]   rem_ff, rem_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RATE_WIDTH:0]   trial;

   always_comb begin
      dividend_in = dividend_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[RATE_WIDTH-1:0], dividend_ff[QUOT_WIDTH-1]};
      if (start) begin
         dividend_in = {length, 16'd0};
         rem_in = '0;
         quot_in = '0;
         count_in = CW'(QUOT_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[QUOT_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, rate}) begin
            rem_in = trial - {1'b0, rate};
            quot_in = {quot_ff[QUOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[QUOT_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctrl.start = start;
   assign ctrl.done = done_ff;
   assign ctrl.overflow = (rate == '0);
   assign quotient = (rate == '0) ? TIME_MAX : TIME_WIDTH'(quot_ff);
endmodule
